FILE: rtl/lrmm_pkg.sv
package lrmm_pkg;

    localparam int unsigned WIDTH = 16;
    localparam int unsigned CNT_W = $clog2(WIDTH);
    localparam int unsigned OP_W  = 3;

    localparam logic [WIDTH-1:0] TAP_MASK = 16'h1BF5;
    localparam logic [WIDTH-1:0] SEED_ONE = 16'h0001;

    localparam logic [OP_W-1:0] OP_MOD     = 3'd0;
    localparam logic [OP_W-1:0] OP_MASK_01 = 3'd1;
    localparam logic [OP_W-1:0] OP_MASK_03 = 3'd2;
    localparam logic [OP_W-1:0] OP_MASK_0F = 3'd3;
    localparam logic [OP_W-1:0] OP_MASK_3F = 3'd4;
    localparam logic [OP_W-1:0] OP_MASK_7F = 3'd5;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    function automatic logic [WIDTH-1:0] mask_of(input logic [OP_W-1:0] op);
        logic [WIDTH-1:0] m;
        unique case (op)
            OP_MASK_01: m = 16'h0001;
            OP_MASK_03: m = 16'h0003;
            OP_MASK_0F: m = 16'h000F;
            OP_MASK_3F: m = 16'h003F;
            OP_MASK_7F: m = 16'h007F;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/lfsr_random_modulo_mask.sv
// 16-bit Galois shift-register random source. Each accepted request steps the
// register once (shift left, XOR with 0x1BF5 when the top bit falls out) and
// returns the new register value together with a reduced draw: the value
// masked to 1, 2, 4, 6 or 7 bits, or the value modulo range_limit (zero for a
// zero limit or an unused operation). Mask draws are written to the output
// register at the edge that takes the request when that register is free,
// and otherwise wait in a hold register. Modulo draws run through a
// restoring remainder unit that retires one dividend bit per cycle; the
// next request is taken once the remainder is written to the output register.
// One request is in flight at a time; a finished result sits in the output
// register while the next request is accepted. Writing cfg_wdata reloads the
// register, with zero replaced by one.
module lfsr_random_modulo_mask (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lrmm_pkg::WIDTH-1:0] cfg_wdata,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [lrmm_pkg::OP_W-1:0]  operation,
    input  logic [lrmm_pkg::WIDTH-1:0] range_limit,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [lrmm_pkg::WIDTH-1:0] draw_value,
    output logic [lrmm_pkg::WIDTH-1:0] register_value
);
    import lrmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] lfsr_reg, lfsr_next;
    logic [WIDTH-1:0] hold_reg, hold_next;
    logic [WIDTH-1:0] draw_reg, draw_next;
    logic [WIDTH-1:0] regval_reg, regval_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [WIDTH-1:0] lfsr_adv;
    logic             accept;
    logic             out_free;
    logic             use_div;
    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [WIDTH-1:0] div_rem;

    assign lfsr_adv  = {lfsr_reg[WIDTH-2:0], 1'b0} ^ (lfsr_reg[WIDTH-1] ? TAP_MASK : '0);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign use_div   = (operation == OP_MOD) && (range_limit != '0);

    assign div_ctl.start = accept && use_div;

    lrmm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (lfsr_adv),
        .divisor   (range_limit),
        .sts       (div_sts),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        lfsr_next      = lfsr_reg;
        hold_next      = hold_reg;
        draw_next      = draw_reg;
        regval_next    = regval_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lfsr_next = lfsr_adv;
                    if (use_div)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        draw_next      = lfsr_adv & mask_of(operation);
                        regval_next    = lfsr_adv;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        hold_next  = lfsr_adv & mask_of(operation);
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    if (out_free)
                    begin
                        draw_next      = div_rem;
                        regval_next    = lfsr_reg;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        hold_next  = div_rem;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    draw_next      = hold_reg;
                    regval_next    = lfsr_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            lfsr_next = (cfg_wdata == '0) ? SEED_ONE : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lfsr_reg      <= SEED_ONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        draw_reg   <= draw_next;
        regval_reg <= regval_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign draw_value     = draw_reg;
    assign register_value = regval_reg;

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> div_sts.busy)
        else $error("divider idle while a modulo request is in flight");

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> ##16 div_sts.done)
        else $error("remainder not ready after one cycle per dividend bit");

    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> rsp_valid_reg)
        else $error("result held back while the output register is empty");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("shift register reached the all-zero lockup value");

endmodule

FILE: rtl/lrmm_div.sv
module lrmm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lrmm_pkg::div_ctl_t         ctl,
    input  logic [lrmm_pkg::WIDTH-1:0] dividend,
    input  logic [lrmm_pkg::WIDTH-1:0] divisor,
    output lrmm_pkg::div_sts_t         sts,
    output logic [lrmm_pkg::WIDTH-1:0] remainder
);
    import lrmm_pkg::*;

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic [WIDTH-1:0] rem_step;
    logic             last;

    assign shifted  = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dsr_reg};
    assign rem_step = diff[WIDTH+1] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
    assign last     = busy_reg && (cnt_reg == CNT_W'(WIDTH - 1));

    assign sts.busy  = busy_reg;
    assign sts.done  = last;
    assign remainder = rem_step;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

endmodule
